// ===== hw/rtl/mvfs_pkg.sv =====
// Shared types, constants and the frame-rate table of the MPEG-2 video frame splitter.
package mvfs_pkg;

  localparam int LENGTH_BITS_DEF = 20;
  localparam int FRAME_LEN_W     = 20;
  localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_MAX = '1;

  localparam logic [23:0] START_PREFIX   = 24'h000001;
  localparam logic [7:0]  START_PICTURE  = 8'h00;
  localparam logic [7:0]  START_SEQUENCE = 8'hB3;
  localparam logic [7:0]  START_SEQ_END  = 8'hB7;

  localparam logic [3:0]  PIC_HDR_BYTES  = 4'd4;
  localparam logic [3:0]  SEQ_HDR_BYTES  = 4'd8;
  localparam logic [2:0]  PTYPE_I        = 3'd1;
  localparam logic [2:0]  PTYPE_P        = 3'd2;
  localparam logic [2:0]  PTYPE_B        = 3'd3;
  localparam logic [3:0]  ASPECT_MIN     = 4'd1;
  localparam logic [3:0]  ASPECT_MAX     = 4'd4;
  localparam logic [15:0] DECODE_DELAY_UNKNOWN = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_PIC  = 2'd1,
    KIND_SEQ  = 2'd2
  } hdr_kind_t;

  typedef struct packed {
    logic [11:0] width;
    logic [11:0] height;
    logic [2:0]  aspect_code;
    logic [11:0] frame_duration;
    logic [20:0] vbv_buffer_bytes;
  } seq_fields_t;

  typedef struct packed {
    logic [9:0]  temporal_reference;
    logic [2:0]  picture_type;
    logic [15:0] decode_delay;
  } pic_fields_t;

  typedef struct packed {
    logic [FRAME_LEN_W-1:0] frame_length;
    logic                   frame_usable;
    seq_fields_t            seq;
    pic_fields_t            pic;
  } frame_result_t;

  // Frame duration in 90 kHz ticks for each frame_rate_code.
  function automatic logic [11:0] rate_ticks(input logic [3:0] code);
    logic [11:0] ticks;
    case (code)
      4'd1:    ticks = 12'd3753;
      4'd2:    ticks = 12'd3750;
      4'd3:    ticks = 12'd3600;
      4'd4:    ticks = 12'd3003;
      4'd5:    ticks = 12'd3000;
      4'd6:    ticks = 12'd1800;
      4'd7:    ticks = 12'd1501;
      4'd8:    ticks = 12'd1500;
      default: ticks = 12'd0;
    endcase
    return ticks;
  endfunction

endpackage

// ===== hw/rtl/mvfs_if.sv =====
// Valid/ready channel interfaces for stream bytes and closed-frame results.
interface mvfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface mvfs_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] frame_length;
  logic        frame_usable;
  logic [11:0] width;
  logic [11:0] height;
  logic [2:0]  aspect_code;
  logic [11:0] frame_duration;
  logic [9:0]  temporal_reference;
  logic [2:0]  picture_type;
  logic [15:0] decode_delay;
  logic [20:0] vbv_buffer_bytes;

  modport source (
    output valid, output frame_length, output frame_usable, output width,
    output height, output aspect_code, output frame_duration,
    output temporal_reference, output picture_type, output decode_delay,
    output vbv_buffer_bytes, input ready
  );
  modport sink (
    input valid, input frame_length, input frame_usable, input width,
    input height, input aspect_code, input frame_duration,
    input temporal_reference, input picture_type, input decode_delay,
    input vbv_buffer_bytes, output ready
  );
endinterface

// ===== hw/rtl/mvfs_parser.sv =====
// Start-code parser: window, header collection and decode, frame byte count.
module mvfs_parser import mvfs_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          byte_accept,
  input  logic [7:0]    data_byte,
  output logic          frame_emit,
  output frame_result_t frame_result
);

  localparam int XW = (LENGTH_BITS > FRAME_LEN_W) ? LENGTH_BITS : FRAME_LEN_W;
  localparam logic [LENGTH_BITS-1:0] CNT_MAX  = '1;
  localparam logic [LENGTH_BITS-1:0] CNT_CODE = LENGTH_BITS'(4);

  logic [31:0]            win_r, win_nxt;
  logic [63:0]            hb_r, hb_nxt;
  logic [3:0]             left_r, left_nxt;
  hdr_kind_t              kind_r, kind_nxt;
  logic                   inside_r, inside_nxt;
  logic                   need_seq_r, need_seq_nxt;
  logic                   need_intra_r, need_intra_nxt;
  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt;
  seq_fields_t            seq_r, seq_nxt;
  pic_fields_t            pic_r, pic_nxt;

  logic [LENGTH_BITS-1:0] cnt_inc;
  logic [LENGTH_BITS-1:0] emit_len;
  logic [XW-1:0]          emit_len_x;
  logic                   check_code;
  logic [3:0]             aspect;
  logic [2:0]             ptype;

  assign cnt_inc = (cnt_r < CNT_MAX) ? cnt_r + LENGTH_BITS'(1) : cnt_r;

  always_comb begin
    win_nxt        = {win_r[23:0], data_byte};
    hb_nxt         = hb_r;
    left_nxt       = left_r;
    kind_nxt       = kind_r;
    inside_nxt     = inside_r;
    need_seq_nxt   = need_seq_r;
    need_intra_nxt = need_intra_r;
    cnt_nxt        = cnt_inc;
    seq_nxt        = seq_r;
    pic_nxt        = pic_r;
    check_code     = 1'b1;
    frame_emit     = 1'b0;
    emit_len       = cnt_inc;
    aspect         = hb_nxt[39:36];
    ptype          = hb_nxt[21:19];

    // Header bytes are collected first; start codes inside a header are ignored
    // unless they end on the last header byte.
    if (left_r != 4'd0) begin
      hb_nxt   = {hb_r[55:0], data_byte};
      left_nxt = left_r - 4'd1;
      aspect   = hb_nxt[39:36];
      ptype    = hb_nxt[21:19];
      if (left_nxt != 4'd0) begin
        check_code = 1'b0;
      end else begin
        if (kind_r == KIND_SEQ) begin
          seq_nxt.width  = hb_nxt[63:52];
          seq_nxt.height = hb_nxt[51:40];
          if (aspect >= ASPECT_MIN && aspect <= ASPECT_MAX) begin
            seq_nxt.aspect_code      = aspect[2:0];
            seq_nxt.frame_duration   = rate_ticks(hb_nxt[35:32]);
            seq_nxt.vbv_buffer_bytes = {hb_nxt[12:3], 11'd0};
            need_seq_nxt             = 1'b0;
          end
        end else if (kind_r == KIND_PIC) begin
          pic_nxt.temporal_reference = hb_nxt[31:22];
          pic_nxt.picture_type       = ptype;
          if (ptype == PTYPE_I || ptype == PTYPE_P || ptype == PTYPE_B) begin
            if (ptype == PTYPE_I) begin
              need_intra_nxt = 1'b0;
            end
            pic_nxt.decode_delay = hb_nxt[18:3];
          end
          inside_nxt = 1'b1;
        end
        kind_nxt = KIND_NONE;
      end
    end

    if (check_code && win_nxt[31:8] == START_PREFIX) begin
      case (win_nxt[7:0])
        START_PICTURE: begin
          if (need_seq_nxt) begin
            inside_nxt = 1'b1;
          end else begin
            if (inside_nxt) begin
              frame_emit = 1'b1;
              emit_len   = (cnt_inc >= CNT_CODE) ? cnt_inc - CNT_CODE : '0;
              inside_nxt = 1'b0;
              cnt_nxt    = CNT_CODE;
            end
            kind_nxt = KIND_PIC;
            left_nxt = PIC_HDR_BYTES;
            hb_nxt   = '0;
          end
        end
        START_SEQUENCE: begin
          if (inside_nxt) begin
            frame_emit = 1'b1;
            emit_len   = (cnt_inc >= CNT_CODE) ? cnt_inc - CNT_CODE : '0;
            inside_nxt = 1'b0;
            cnt_nxt    = CNT_CODE;
          end
          kind_nxt = KIND_SEQ;
          left_nxt = SEQ_HDR_BYTES;
          hb_nxt   = '0;
        end
        START_SEQ_END: begin
          if (inside_nxt) begin
            // The end code belongs to the closing frame; the window restarts.
            frame_emit = 1'b1;
            emit_len   = cnt_inc;
            inside_nxt = 1'b0;
            cnt_nxt    = '0;
            win_nxt    = '1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign emit_len_x = XW'(emit_len);

  always_comb begin
    frame_result.frame_length = (emit_len_x > XW'(FRAME_LEN_MAX)) ?
                                FRAME_LEN_MAX : emit_len_x[FRAME_LEN_W-1:0];
    frame_result.frame_usable = !need_seq_nxt && !need_intra_nxt;
    frame_result.seq          = seq_nxt;
    frame_result.pic          = pic_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r        <= '1;
      hb_r         <= '0;
      left_r       <= 4'd0;
      kind_r       <= KIND_NONE;
      inside_r     <= 1'b0;
      need_seq_r   <= 1'b1;
      need_intra_r <= 1'b1;
      cnt_r        <= '0;
      seq_r        <= '0;
      pic_r        <= '{temporal_reference: '0, picture_type: '0,
                        decode_delay: DECODE_DELAY_UNKNOWN};
    end else if (byte_accept) begin
      win_r        <= win_nxt;
      hb_r         <= hb_nxt;
      left_r       <= left_nxt;
      kind_r       <= kind_nxt;
      inside_r     <= inside_nxt;
      need_seq_r   <= need_seq_nxt;
      need_intra_r <= need_intra_nxt;
      cnt_r        <= cnt_nxt;
      seq_r        <= seq_nxt;
      pic_r        <= pic_nxt;
    end
  end

endmodule

// ===== hw/rtl/mpeg2_video_frame_splitter_top.sv =====
// Latency: a frame result is valid in the cycle after the byte that closes the frame.
// Throughput: one stream byte per cycle while results drain; a result waits in a single
// output register, and while it waits with out_ch.ready low the input is held off,
// whether or not the next byte would close a frame.
// Reset: synchronous active-low rst_n clears the parser state and the result valid flag.
module mpeg2_video_frame_splitter_top import mvfs_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  mvfs_in_if.sink    in_ch,
  mvfs_out_if.source out_ch
);

  logic          in_ready_w;
  logic          in_accept;
  logic          frame_emit;
  frame_result_t frame_result;
  logic          out_valid_r;
  frame_result_t out_data_r;

  // The input is held off only while a result waits and the receiver is not ready.
  assign in_ready_w  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = in_ready_w;
  assign in_accept   = in_ch.valid && in_ready_w;

  mvfs_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_accept (in_accept),
    .data_byte   (in_ch.data_byte),
    .frame_emit  (frame_emit),
    .frame_result(frame_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && frame_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && frame_emit) begin
      out_data_r <= frame_result;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.frame_length       = out_data_r.frame_length;
  assign out_ch.frame_usable       = out_data_r.frame_usable;
  assign out_ch.width              = out_data_r.seq.width;
  assign out_ch.height             = out_data_r.seq.height;
  assign out_ch.aspect_code        = out_data_r.seq.aspect_code;
  assign out_ch.frame_duration     = out_data_r.seq.frame_duration;
  assign out_ch.vbv_buffer_bytes   = out_data_r.seq.vbv_buffer_bytes;
  assign out_ch.temporal_reference = out_data_r.pic.temporal_reference;
  assign out_ch.picture_type       = out_data_r.pic.picture_type;
  assign out_ch.decode_delay       = out_data_r.pic.decode_delay;

endmodule
